### rtl/core/gift_wrap_convex_hull_unit_macros.svh
// Assertion macros shared by the convex hull unit.
`ifndef GIFT_WRAP_CONVEX_HULL_UNIT_MACROS_SVH
`define GIFT_WRAP_CONVEX_HULL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWCH_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("convex hull unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GWCH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("convex hull unit: next-cycle check failed");

`endif

### rtl/core/gwch_pkg.sv
// Shared constants, codes and controller/datapath interface types of the hull unit.
package gwch_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int MIN_POINTS = 3;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FEW   = 2'd1,
      STAT_MANY  = 2'd2,
      STAT_STEPS = 2'd3
   } status_code_type;

   // Source of the point store read address.
   typedef enum logic [1:0] {
      RD_IDX  = 2'd0,
      RD_CAND = 2'd1,
      RD_HULL = 2'd2
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;
      logic            set_clear;
      logic            idx_clear;
      logic            idx_inc;
      logic            step_clear;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            hb_rd_en;
      logic            find_cmp;
      logic            vtx_begin;
      logic            cand_load;
      logic            diff_en;
      logic            mul_en;
      logic            cross_cmp;
      logic            advance;
      logic            out_point;
      logic            out_error;
      status_code_type err_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic overflow;
      logic too_few;
      logic idx_end_cnt;
      logic idx_end_step;
      logic step_full;
      logic cand_is_start;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/gwch_datapath.sv
// Point store, hull index buffer, cross product arithmetic and result register.
module gwch_datapath import gwch_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output dp_status_type                sts,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_hull_x,
   output logic signed [COORD_BITS-1:0] rsp_hull_y,
   output logic                         rsp_hull_last,
   output logic [1:0]                   rsp_status
);

   // Point memory holds {y, x}; hull memory holds vertex indexes in walk order.
   logic [2*COORD_BITS-1:0] pt_mem [MAX_POINTS];
   logic [IDX_W-1:0]        hb_mem [MAX_POINTS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [2*COORD_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]        hb_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    store_en;

   logic [IDX_W-1:0]              start_idx_ff, cur_idx_ff, cand_idx_ff;
   logic signed [COORD_BITS-1:0]  cur_x_ff, cur_y_ff, cand_x_ff, cand_y_ff;
   logic signed [COORD_BITS-1:0]  p_x, p_y;
   logic [CNT_W-1:0]              cand_sum;
   logic [IDX_W-1:0]              cand_next;
   logic                          find_better;

   logic signed [DIFF_W-1:0] bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0]  rsp_x_ff, rsp_y_ff;
   logic                          rsp_last_ff;
   logic [1:0]                    rsp_status_ff;

   assign p_x = $signed(rd_data_ff[COORD_BITS-1:0]);
   assign p_y = $signed(rd_data_ff[2*COORD_BITS-1:COORD_BITS]);

   // The first candidate is the vertex after the current one, wrapping at the set size.
   assign cand_sum  = CNT_W'(cur_idx_ff) + CNT_W'(1);
   assign cand_next = (cand_sum == count_ff) ? '0 : cand_sum[IDX_W-1:0];

   // Read address selection for the point memory.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:  rd_addr = idx_ff;
         RD_CAND: rd_addr = cand_next;
         RD_HULL: rd_addr = hb_data_ff;
         default: rd_addr = idx_ff;
      endcase
   end

   assign store_en = cmd.load && (count_ff < CNT_W'(MAX_POINTS));

   // Point memory: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (store_en) begin
         pt_mem[count_ff[IDX_W-1:0]] <= {req_point_y, req_point_x};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= pt_mem[rd_addr];
      end
   end

   // Hull index memory: written once per vertex, read back during emission.
   always_ff @(posedge clock) begin
      if (cmd.vtx_begin) begin
         hb_mem[step_ff[IDX_W-1:0]] <= cur_idx_ff;
      end
      if (cmd.hb_rd_en) begin
         hb_data_ff <= hb_mem[idx_ff];
      end
   end

   // Set size, overflow flag, step and scan counters.
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.set_clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (cmd.load) begin
         if (store_en) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      step_in = step_ff;
      if (cmd.step_clear) begin
         step_in = '0;
      end else if (cmd.vtx_begin) begin
         step_in = step_ff + CNT_W'(1);
      end

      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         step_ff     <= '0;
         idx_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         step_ff     <= step_in;
         idx_ff      <= idx_in;
      end
   end

   // Lowest y wins, then lowest x; the first point is always taken.
   assign find_better = (idx_ff == '0) || (p_y < cur_y_ff) ||
                        ((p_y == cur_y_ff) && (p_x < cur_x_ff));

   // Start, current and candidate vertex registers.
   always_ff @(posedge clock) begin
      if (cmd.find_cmp && find_better) begin
         start_idx_ff <= idx_ff;
         cur_idx_ff   <= idx_ff;
         cur_x_ff     <= p_x;
         cur_y_ff     <= p_y;
      end else if (cmd.advance) begin
         cur_idx_ff <= cand_idx_ff;
         cur_x_ff   <= cand_x_ff;
         cur_y_ff   <= cand_y_ff;
      end

      if (cmd.vtx_begin) begin
         cand_idx_ff <= cand_next;
      end else if (cmd.cand_load) begin
         cand_x_ff <= p_x;
         cand_y_ff <= p_y;
      end else if (cmd.cross_cmp && (prod_a_ff < prod_b_ff)) begin
         // A negative cross product moves the candidate to the scanned point.
         cand_idx_ff <= idx_ff;
         cand_x_ff   <= p_x;
         cand_y_ff   <= p_y;
      end
   end

   // Cross product: differences, then both products, each stage registered.
   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         bx_ff <= $signed({cand_x_ff[COORD_BITS-1], cand_x_ff})
                - $signed({cur_x_ff[COORD_BITS-1], cur_x_ff});
         by_ff <= $signed({cand_y_ff[COORD_BITS-1], cand_y_ff})
                - $signed({cur_y_ff[COORD_BITS-1], cur_y_ff});
         cx_ff <= $signed({p_x[COORD_BITS-1], p_x})
                - $signed({cur_x_ff[COORD_BITS-1], cur_x_ff});
         cy_ff <= $signed({p_y[COORD_BITS-1], p_y})
                - $signed({cur_y_ff[COORD_BITS-1], cur_y_ff});
      end
      if (cmd.mul_en) begin
         prod_a_ff <= bx_ff * cy_ff;
         prod_b_ff <= by_ff * cx_ff;
      end
   end

   // Result register: a new beat may load in the cycle the previous one is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_point || cmd.out_error) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_point) begin
         rsp_x_ff      <= p_x;
         rsp_y_ff      <= p_y;
         rsp_last_ff   <= sts.idx_end_step;
         rsp_status_ff <= STAT_OK;
      end else if (cmd.out_error) begin
         rsp_x_ff      <= '0;
         rsp_y_ff      <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= cmd.err_code;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hull_x    = rsp_x_ff;
   assign rsp_hull_y    = rsp_y_ff;
   assign rsp_hull_last = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

   // Status back to the controller.
   assign sts.overflow      = overflow_ff;
   assign sts.too_few       = count_ff < CNT_W'(MIN_POINTS);
   assign sts.idx_end_cnt   = CNT_W'(idx_ff) == (count_ff - CNT_W'(1));
   assign sts.idx_end_step  = CNT_W'(idx_ff) == (step_ff - CNT_W'(1));
   assign sts.step_full     = step_ff >= count_ff;
   assign sts.cand_is_start = cand_idx_ff == start_idx_ff;
   assign sts.out_free      = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/core/gwch_ctrl.sv
// Sequencer for loading, start search, hull walk and result emission.
module gwch_ctrl import gwch_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last_point,
   output logic          req_stall,
   input  dp_status_type sts,
   output cmd_type       cmd
);

   typedef enum logic [14:0] {
      S_LOAD      = 15'b000000000000001,
      S_CHECK     = 15'b000000000000010,
      S_FIND_RD   = 15'b000000000000100,
      S_FIND_CMP  = 15'b000000000001000,
      S_VTX       = 15'b000000000010000,
      S_CAND      = 15'b000000000100000,
      S_SCAN_RD   = 15'b000000001000000,
      S_SCAN_DIFF = 15'b000000010000000,
      S_SCAN_MUL  = 15'b000000100000000,
      S_SCAN_CMP  = 15'b000001000000000,
      S_ADVANCE   = 15'b000010000000000,
      S_EMIT_HB   = 15'b000100000000000,
      S_EMIT_RD   = 15'b001000000000000,
      S_EMIT_OUT  = 15'b010000000000000,
      S_ERROR     = 15'b100000000000000
   } state_type;

   state_type       state_ff, state_in;
   status_code_type err_ff, err_in;

   assign req_stall = (state_ff != S_LOAD);

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      cmd          = '0;
      cmd.rd_sel   = RD_IDX;
      cmd.err_code = err_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_point) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            cmd.idx_clear  = 1'b1;
            cmd.step_clear = 1'b1;
            if (sts.overflow) begin
               err_in   = STAT_MANY;
               state_in = S_ERROR;
            end else if (sts.too_few) begin
               err_in   = STAT_FEW;
               state_in = S_ERROR;
            end else begin
               state_in = S_FIND_RD;
            end
         end
         S_FIND_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            cmd.find_cmp = 1'b1;
            if (sts.idx_end_cnt) begin
               state_in = S_VTX;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_FIND_RD;
            end
         end
         S_VTX: begin
            if (sts.step_full) begin
               err_in   = STAT_STEPS;
               state_in = S_ERROR;
            end else begin
               cmd.vtx_begin = 1'b1;
               cmd.idx_clear = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_CAND;
               state_in      = S_CAND;
            end
         end
         S_CAND: begin
            cmd.cand_load = 1'b1;
            state_in      = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SCAN_DIFF;
         end
         S_SCAN_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = S_SCAN_MUL;
         end
         S_SCAN_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.cross_cmp = 1'b1;
            if (sts.idx_end_cnt) begin
               state_in = S_ADVANCE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_ADVANCE: begin
            cmd.advance = 1'b1;
            if (sts.cand_is_start) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_EMIT_HB;
            end else begin
               state_in = S_VTX;
            end
         end
         S_EMIT_HB: begin
            cmd.hb_rd_en = 1'b1;
            state_in     = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HULL;
            state_in   = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (sts.out_free) begin
               cmd.out_point = 1'b1;
               if (sts.idx_end_step) begin
                  cmd.set_clear = 1'b1;
                  state_in      = S_LOAD;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_EMIT_HB;
               end
            end
         end
         S_ERROR: begin
            if (sts.out_free) begin
               cmd.out_error = 1'b1;
               cmd.set_clear = 1'b1;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
   end

endmodule

### rtl/core/gift_wrap_convex_hull_unit.sv
// Top level of the gift-wrapping convex hull unit: controller, datapath and checks.
//
//   Channel  Dir  Handshake            Fields
//   req      in   req_valid/req_stall  point_x, point_y, last_point
//   rsp      out  rsp_valid/rsp_stall  hull_x, hull_y, hull_last, status
//
// Points load at one beat per cycle; the beat with last_point starts a run, during
// which req_stall stays high. The single read port of the point memory and the
// four-step cross product per scanned point set the length of a run.
// Reset clears the controller, set size and result valid; the memories need no clearing.
// A stalled rsp beat holds the walk only at emission; the last beat may wait while
// the next set loads.
`include "gift_wrap_convex_hull_unit_macros.svh"

module gift_wrap_convex_hull_unit import gwch_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_last_point,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_hull_x,
   output logic signed [COORD_BITS-1:0] rsp_hull_y,
   output logic                         rsp_hull_last,
   output logic [1:0]                   rsp_status
);

   cmd_type       cmd;
   dp_status_type sts;

   // Sequencer.
   gwch_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_stall      (req_stall),
      .sts            (sts),
      .cmd            (cmd)
   );

   // Storage and arithmetic.
   gwch_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hull_x    (rsp_hull_x),
      .rsp_hull_y    (rsp_hull_y),
      .rsp_hull_last (rsp_hull_last),
      .rsp_status    (rsp_status)
   );

   // A result beat is never loaded over one that is still waiting.
   `GWCH_ASSERT_SAME(a_no_overwrite, cmd.out_point || cmd.out_error, sts.out_free)
   // Error results always close the run.
   `GWCH_ASSERT_SAME(a_error_is_last, rsp_valid && (rsp_status != STAT_OK), rsp_hull_last)
   // The beat that closes a set makes the unit busy.
   `GWCH_ASSERT_NEXT(a_busy_after_last, req_valid && !req_stall && req_last_point, req_stall)

endmodule

### verif/tb_top.sv
// Self-checking testbench for the gift-wrapping convex hull unit.
module tb_top;
   import gwch_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // One expected result beat.
   typedef struct {
      coord_type       x;
      coord_type       y;
      logic            last;
      status_code_type status;
   } hull_beat_type;

   // Shapes of random point sets.
   typedef enum int {
      SHAPE_WIDE,
      SHAPE_GRID,
      SHAPE_CURVE,
      SHAPE_CORNERS,
      SHAPE_BOX
   } shape_type;

   // Receiver stall patterns.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_HOLD
   } stall_mode_type;

   localparam int RANDOM_ITEMS  = 245;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 1000000;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   coord_type req_point_x;
   coord_type req_point_y;
   logic      req_last_point;
   logic      rsp_valid;
   logic      rsp_stall;
   coord_type rsp_hull_x;
   coord_type rsp_hull_y;
   logic      rsp_hull_last;
   logic [1:0] rsp_status;

   // Copy of the point set being loaded, as the block should hold it.
   coord_type     set_x [MAX_POINTS];
   coord_type     set_y [MAX_POINTS];
   int            set_count    = 0;
   bit            set_overflow = 1'b0;
   hull_beat_type hull_expected [$];

   // Points queued up by a test before they are sent as one set.
   coord_type plan_x [$];
   coord_type plan_y [$];

   int error_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int cycle_count = 0;

   gift_wrap_convex_hull_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hull_x     (rsp_hull_x),
      .rsp_hull_y     (rsp_hull_y),
      .rsp_hull_last  (rsp_hull_last),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // The receiver switches between stall patterns of random length.
   initial begin : stall_pattern
      stall_mode_type mode;
      int             run;
      rsp_stall = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         run  = (mode == STALL_HOLD) ? $urandom_range(1, 20) : $urandom_range(5, 80);
         repeat (run) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // Each accepted result beat is compared with the oldest expected one.
   always @(posedge clock) begin : check_hull
      hull_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hull_expected.size() == 0) begin
            $error("unexpected hull beat: x %0d y %0d last %0b status %0d",
                   rsp_hull_x, rsp_hull_y, rsp_hull_last, rsp_status);
            error_count++;
         end else begin
            want = hull_expected.pop_front();
            if (rsp_hull_x !== want.x) begin
               $error("hull_x: expected %0d, got %0d", want.x, rsp_hull_x);
               error_count++;
            end
            if (rsp_hull_y !== want.y) begin
               $error("hull_y: expected %0d, got %0d", want.y, rsp_hull_y);
               error_count++;
            end
            if (rsp_hull_last !== want.last) begin
               $error("hull_last: expected %0b, got %0b", want.last, rsp_hull_last);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Signed area of the turn a->b->c over stored points, exact in 64 bits.
   function automatic longint turn_of(input int a, input int b, input int c);
      longint bx, by, cx, cy;
      bx = longint'(set_x[b]) - longint'(set_x[a]);
      by = longint'(set_y[b]) - longint'(set_y[a]);
      cx = longint'(set_x[c]) - longint'(set_x[a]);
      cy = longint'(set_y[c]) - longint'(set_y[a]);
      return bx * cy - by * cx;
   endfunction

   function automatic void add_hull_beat(input coord_type x, input coord_type y,
                                         input logic last, input status_code_type status);
      hull_beat_type beat;
      beat.x      = x;
      beat.y      = y;
      beat.last   = last;
      beat.status = status;
      hull_expected.insert(hull_expected.size(), beat);
   endfunction

   // Walk the hull of the stored set and queue its vertices, or a step limit error.
   function automatic void wrap_hull();
      int n, start, cur, cand, steps, i;
      int path [$];
      n     = set_count;
      start = 0;
      for (i = 1; i < n; i++) begin
         if (set_y[i] < set_y[start] || (set_y[i] == set_y[start] && set_x[i] < set_x[start]))
            start = i;
      end
      cur   = start;
      steps = 0;
      do begin
         if (steps >= n) begin
            add_hull_beat('0, '0, 1'b1, STAT_STEPS);
            return;
         end
         path.insert(path.size(), cur);
         steps++;
         cand = (cur + 1) % n;
         for (i = 0; i < n; i++) begin
            if (turn_of(cur, cand, i) < 0)
               cand = i;
         end
         cur = cand;
      end while (cur != start);
      for (i = 0; i < path.size(); i++)
         add_hull_beat(set_x[path[i]], set_y[path[i]], i == path.size() - 1, STAT_OK);
   endfunction

   // Track one accepted point; a last marker closes the set.
   function automatic void record_point(input coord_type x, input coord_type y,
                                        input logic last);
      if (set_count < MAX_POINTS) begin
         set_x[set_count] = x;
         set_y[set_count] = y;
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (last) begin
         if (set_overflow)
            add_hull_beat('0, '0, 1'b1, STAT_MANY);
         else if (set_count < MIN_POINTS)
            add_hull_beat('0, '0, 1'b1, STAT_FEW);
         else
            wrap_hull();
         set_count    = 0;
         set_overflow = 1'b0;
      end
   endfunction

   // Send one point beat; bursts of random length are separated by random gaps.
   task automatic send_point(input coord_type x, input coord_type y, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_point_x    <= x;
      req_point_y    <= y;
      req_last_point <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      record_point(x, y, last);
      burst_left--;
      items_sent++;
   endtask

   task automatic plan_point(input int x, input int y);
      plan_x.insert(plan_x.size(), coord_type'(x));
      plan_y.insert(plan_y.size(), coord_type'(y));
   endtask

   // Send the planned points as one set, the last one carrying the marker.
   task automatic send_plan();
      int k;
      for (k = 0; k < plan_x.size(); k++)
         send_point(plan_x[k], plan_y[k], k == plan_x.size() - 1);
      plan_x.delete();
      plan_y.delete();
   endtask

   // Hold the sender until every expected beat has arrived, then let the block settle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hull_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Convex points on a parabola; every one of them lies on the hull.
   task automatic plan_curve(input int n, input int ax, input int by, input bit flip,
                             input bit swap);
      int k, t, x, y;
      for (k = 0; k < n; k++) begin
         t = k - n / 2;
         x = t * ax;
         y = flip ? -(t * t * by) : t * t * by;
         if (swap)
            plan_point(y, x);
         else
            plan_point(x, y);
      end
   endtask

   function automatic int corner_value();
      case ($urandom_range(0, 4))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return -1;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Sets of one and two points are too small for a hull.
   task automatic test_too_few();
      plan_point(5, 5);
      send_plan();
      plan_point(-1, 2);
      plan_point(3, -4);
      send_plan();
      drain_results();
   endtask

   // Corners at the coordinate extremes, an interior point and a point on an edge.
   task automatic test_extreme_square();
      plan_point(0, 0);
      plan_point(32767, -32768);
      plan_point(-32768, 32767);
      plan_point(32767, 32767);
      plan_point(0, -32768);
      plan_point(-32768, -32768);
      send_plan();
      drain_results();
   endtask

   // Several points share the lowest y, and the start point is duplicated.
   task automatic test_start_ties();
      plan_point(10, -5);
      plan_point(-20, -5);
      plan_point(-20, -5);
      plan_point(0, 30);
      plan_point(15, 8);
      send_plan();
      drain_results();
   endtask

   // Collinear and coincident sets, and a duplicate that traps the walk.
   task automatic test_degenerate_sets();
      plan_point(0, 0);
      plan_point(1, 1);
      plan_point(2, 2);
      plan_point(-3, -3);
      send_plan();
      repeat (3) plan_point(7, 7);
      send_plan();
      plan_point(0, 0);
      plan_point(4, 0);
      plan_point(0, 4);
      plan_point(0, 0);
      plan_point(1, 1);
      send_plan();
      drain_results();
   endtask

   // A full store with every point on the hull gives the longest result run.
   task automatic test_full_store();
      int k, j;
      coord_type tx, ty;
      plan_curve(MAX_POINTS, 1000, 31, 1'b0, 1'b0);
      for (k = plan_x.size() - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tx = plan_x[k]; plan_x[k] = plan_x[j]; plan_x[j] = tx;
         ty = plan_y[k]; plan_y[k] = plan_y[j]; plan_y[j] = ty;
      end
      send_plan();
      drain_results();
   endtask

   // Points beyond capacity are dropped; the set then ends in an error and the next
   // set starts fresh.
   task automatic test_store_overflow();
      int k;
      for (k = 0; k < MAX_POINTS + 1; k++)
         plan_point(k * 7 - 200, (k * 13) % 101);
      send_plan();
      for (k = 0; k < MAX_POINTS + 3; k++)
         plan_point(corner_value(), corner_value());
      send_plan();
      plan_point(-9, -9);
      plan_point(9, -9);
      plan_point(0, 9);
      send_plan();
      drain_results();
   endtask

   // One random set of a random shape and size.
   task automatic send_random_set();
      int        n, k, j, r, ax, by, half, ox, oy, spread;
      shape_type shape;
      coord_type tx, ty;
      r = $urandom_range(0, 99);
      if (r < 8)
         n = $urandom_range(1, 2);
      else if (r < 90)
         n = $urandom_range(3, 16);
      else if (r < 99)
         n = $urandom_range(17, 40);
      else
         n = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 4);
      shape = shape_type'($urandom_range(0, 4));
      case (shape)
         SHAPE_CURVE: begin
            half = n / 2 + 1;
            ax   = $urandom_range(1, 32000 / n);
            by   = $urandom_range(1, 32000 / (half * half));
            plan_curve(n, ax, by, $urandom_range(0, 1), $urandom_range(0, 1));
         end
         SHAPE_BOX: begin
            ox     = int'($urandom_range(0, 32000)) - 16000;
            oy     = int'($urandom_range(0, 32000)) - 16000;
            spread = $urandom_range(1, 2000);
            for (k = 0; k < n; k++)
               plan_point(ox + int'($urandom_range(0, 2 * spread)) - spread,
                          oy + int'($urandom_range(0, 2 * spread)) - spread);
         end
         default: begin
            for (k = 0; k < n; k++) begin
               if (shape == SHAPE_GRID)
                  plan_point(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3);
               else if (shape == SHAPE_CORNERS)
                  plan_point(corner_value(), corner_value());
               else
                  plan_point(int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768);
            end
         end
      endcase
      for (k = plan_x.size() - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tx = plan_x[k]; plan_x[k] = plan_x[j]; plan_x[j] = tx;
         ty = plan_y[k]; plan_y[k] = plan_y[j]; plan_y[j] = ty;
      end
      send_plan();
   endtask

   // Random sets back to back, now and then with the sender held until all results land.
   task automatic test_random_sets();
      int base;
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         send_random_set();
         if ($urandom_range(0, 9) == 0)
            drain_results();
      end
   endtask

   // Reset, then the tests in turn, then the final verdict.
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_point_x    = '0;
      req_point_y    = '0;
      req_last_point = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_too_few();
      test_extreme_square();
      test_start_ties();
      test_degenerate_sets();
      test_full_store();
      test_store_overflow();
      test_random_sets();
      drain_results();
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
